// ===== src/capfd_pkg.sv =====
// ----------------------------------------------------------------------------
// capfd_pkg: shared types and constants of the coherent demodulator
// Sizes, register indexes, the quarter-wave sine table and its lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package capfd_pkg;

  localparam int PHASE_BITS     = 32;
  localparam int SINE_ADDR_BITS = 10;
  localparam int SAMPLE_BITS    = 16;
  localparam int ACC_BITS       = 48;
  localparam int CNT_BITS       = 16;
  localparam int MODE_BITS      = 2;
  localparam int SINE_BITS      = 16;
  localparam int SINE_MAG_BITS  = 15;
  localparam int PROD_BITS      = SAMPLE_BITS + SINE_BITS;
  localparam int QUARTER_BITS   = SINE_ADDR_BITS - 2;
  localparam int QUARTER_LEN    = 1 << QUARTER_BITS;

  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 48;
  localparam int IN_TDATA_BITS  = 16;
  localparam int OUT_TDATA_BITS = 24;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  // mode register: bit 1 selects FSK, otherwise PSK or ASK
  localparam int                   MODE_FSK_BIT = 1;
  localparam logic [MODE_BITS-1:0] MODE_ASK     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_PSK     = 2'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_MODE      = 3'd0,
    CFG_SPB       = 3'd1,
    CFG_CARRIER   = 3'd2,
    CFG_SPACE     = 3'd3,
    CFG_MARK      = 3'd4,
    CFG_THRESHOLD = 3'd5
  } cfg_reg_e;

  localparam logic [CNT_BITS-1:0]         SPB_RESET       = 16'd2000;
  localparam logic [PHASE_BITS-1:0]       CARRIER_RESET   = 32'd4294967;
  localparam logic [PHASE_BITS-1:0]       SPACE_RESET     = 32'd6442451;
  localparam logic [PHASE_BITS-1:0]       MARK_RESET      = 32'd8589935;
  localparam logic signed [ACC_BITS-1:0]  THRESHOLD_RESET = 48'sd67041755136;

  typedef logic signed [SINE_BITS-1:0] sine_t;

  typedef struct packed {
    sine_t primary;
    sine_t mark;
  } carrier_t;

  typedef struct packed {
    logic                        valid;
    logic                        frame_start;
    logic signed [PROD_BITS-1:0] prod_p;
    logic signed [PROD_BITS-1:0] prod_m;
  } mix_t;

  typedef logic [SINE_MAG_BITS-1:0] sine_rom_t [QUARTER_LEN];

  // Taylor series to x^11 in Q30, rounded to Q14; elaboration only
  function automatic logic [SINE_MAG_BITS-1:0] quarter_sine(int r);
    longint unsigned x, x2, t, s;
    x  = (longint'(r) * HALF_PI_Q30) >> QUARTER_BITS;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + (64'd1 << 15)) >> 16;
    return s[SINE_MAG_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int i = 0; i < QUARTER_LEN; i++) begin
      rom[i] = quarter_sine(i);
    end
    return rom;
  endfunction

  localparam sine_rom_t                SINE_ROM  = build_sine_rom();
  localparam logic [SINE_MAG_BITS-1:0] SINE_PEAK = quarter_sine(QUARTER_LEN);

  // fold into the first quadrant; the mirrored index of zero is the peak
  function automatic sine_t sine_lookup(logic [PHASE_BITS-1:0] phase);
    logic [SINE_ADDR_BITS-1:0] addr;
    logic [1:0]                quad;
    logic [QUARTER_BITS-1:0]   r;
    logic [SINE_MAG_BITS-1:0]  mag;
    addr = phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad = addr[SINE_ADDR_BITS-1 -: 2];
    r    = addr[QUARTER_BITS-1:0];
    if (!quad[0]) begin
      mag = SINE_ROM[r];
    end else if (r == '0) begin
      mag = SINE_PEAK;
    end else begin
      mag = SINE_ROM[QUARTER_BITS'(~r + 1'b1)];
    end
    if (quad[1]) begin
      return -sine_t'({1'b0, mag});
    end
    return sine_t'({1'b0, mag});
  endfunction

endpackage

`default_nettype wire

// ===== src/capfd_nco.sv =====
// ----------------------------------------------------------------------------
// capfd_nco: carrier oscillators
// Two phase accumulators with the sine of each current phase held ready.
// ----------------------------------------------------------------------------
`default_nettype none

module capfd_nco
  import capfd_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  step_i,
  input  wire logic                  frame_start_i,
  input  wire logic                  fsk_i,
  input  wire logic [PHASE_BITS-1:0] carrier_inc_i,
  input  wire logic [PHASE_BITS-1:0] space_inc_i,
  input  wire logic [PHASE_BITS-1:0] mark_inc_i,
  output carrier_t                   carrier_o
);

  logic [PHASE_BITS-1:0] phase_p_q, phase_p_d;
  logic [PHASE_BITS-1:0] phase_m_q, phase_m_d;
  sine_t                 sin_p_q, sin_m_q;
  logic [PHASE_BITS-1:0] base_p, base_m;

  always_comb begin
    base_p    = frame_start_i ? '0 : phase_p_q;
    base_m    = frame_start_i ? '0 : phase_m_q;
    phase_p_d = base_p + (fsk_i ? space_inc_i : carrier_inc_i);
    phase_m_d = base_m + mark_inc_i;
  end

  // a frame start uses phase zero for this word
  assign carrier_o.primary = frame_start_i ? sine_lookup('0) : sin_p_q;
  assign carrier_o.mark    = frame_start_i ? sine_lookup('0) : sin_m_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_p_q <= '0;
      phase_m_q <= '0;
      sin_p_q   <= sine_lookup('0);
      sin_m_q   <= sine_lookup('0);
    end else if (step_i) begin
      phase_p_q <= phase_p_d;
      phase_m_q <= phase_m_d;
      sin_p_q   <= sine_lookup(phase_p_d);
      sin_m_q   <= sine_lookup(phase_m_d);
    end
  end

endmodule

`default_nettype wire

// ===== src/capfd_mixer.sv =====
// ----------------------------------------------------------------------------
// capfd_mixer: sample register and carrier products
// Registers the accepted word with its carriers, then the two products.
// ----------------------------------------------------------------------------
`default_nettype none

module capfd_mixer
  import capfd_pkg::*;
(
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          accept_i,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_i,
  input  wire logic                          frame_start_i,
  input  wire carrier_t                      carrier_i,
  output mix_t                               mix_o
);

  logic                          valid_q;
  logic                          fs_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  carrier_t                      carrier_q;
  mix_t                          mix_d;
  logic                          mix_valid_q;
  logic                          mix_fs_q;
  logic signed [PROD_BITS-1:0]   prod_p_q, prod_m_q;

  always_comb begin
    mix_d.valid       = valid_q;
    mix_d.frame_start = fs_q;
    mix_d.prod_p      = PROD_BITS'(sample_q * carrier_q.primary);
    mix_d.prod_m      = PROD_BITS'(sample_q * carrier_q.mark);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      mix_valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q     <= accept_i;
      mix_valid_q <= mix_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fs_q      <= frame_start_i;
      sample_q  <= sample_i;
      carrier_q <= carrier_i;
      mix_fs_q  <= mix_d.frame_start;
      prod_p_q  <= mix_d.prod_p;
      prod_m_q  <= mix_d.prod_m;
    end
  end

  always_comb begin
    mix_o.valid       = mix_valid_q;
    mix_o.frame_start = mix_fs_q;
    mix_o.prod_p      = prod_p_q;
    mix_o.prod_m      = prod_m_q;
  end

endmodule

`default_nettype wire

// ===== src/capfd_decider.sv =====
// ----------------------------------------------------------------------------
// capfd_decider: integrators, per-sample rule and bit vote
// Accumulates both products, tallies ones and loads the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module capfd_decider
  import capfd_pkg::*;
(
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire mix_t                       mix_i,
  input  wire logic [MODE_BITS-1:0]       mode_i,
  input  wire logic [CNT_BITS-1:0]        spb_i,
  input  wire logic signed [ACC_BITS-1:0] threshold_i,
  input  wire logic                       out_ready_i,
  output logic                            out_valid_o,
  output logic                            out_bit_o,
  output logic [CNT_BITS-1:0]             out_count_o
);

  localparam logic signed [ACC_BITS-1:0] AccMax = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS-1:0] AccMin = {1'b1, {(ACC_BITS-1){1'b0}}};
  localparam logic [CNT_BITS-1:0]        CntMax = '1;

  logic signed [ACC_BITS-1:0] integ_p_q, integ_p_d;
  logic signed [ACC_BITS-1:0] integ_m_q, integ_m_d;
  logic [CNT_BITS-1:0]        count_q, count_d;
  logic [CNT_BITS-1:0]        tally_q, tally_d;
  logic                       out_valid_q, out_valid_d;
  logic                       out_bit_q;
  logic [CNT_BITS-1:0]        out_count_q;

  logic signed [ACC_BITS-1:0] base_p, base_m, new_p, new_m;
  logic signed [ACC_BITS:0]   sum_p, sum_m;
  logic [CNT_BITS-1:0]        base_cnt, base_tally, new_cnt, new_tally, period;
  logic [CNT_BITS:0]          twice;
  logic                       fsk, one, bit_end, bit_val;

  always_comb begin
    fsk        = mode_i[MODE_FSK_BIT];
    base_p     = mix_i.frame_start ? '0 : integ_p_q;
    base_m     = mix_i.frame_start ? '0 : integ_m_q;
    base_cnt   = mix_i.frame_start ? '0 : count_q;
    base_tally = mix_i.frame_start ? '0 : tally_q;

    sum_p = (ACC_BITS+1)'(base_p) + (ACC_BITS+1)'(mix_i.prod_p);
    sum_m = (ACC_BITS+1)'(base_m) + (ACC_BITS+1)'(mix_i.prod_m);
    // clamp when the carry out disagrees with the sign
    if (sum_p[ACC_BITS] != sum_p[ACC_BITS-1]) begin
      new_p = sum_p[ACC_BITS] ? AccMin : AccMax;
    end else begin
      new_p = sum_p[ACC_BITS-1:0];
    end
    if (sum_m[ACC_BITS] != sum_m[ACC_BITS-1]) begin
      new_m = sum_m[ACC_BITS] ? AccMin : AccMax;
    end else begin
      new_m = sum_m[ACC_BITS-1:0];
    end

    if (fsk) begin
      one = new_p > new_m;
    end else if (mode_i == MODE_PSK) begin
      one = new_p[ACC_BITS-1];
    end else begin
      one = new_p > threshold_i;
    end

    new_tally = base_tally + CNT_BITS'(one && (base_tally != CntMax));
    new_cnt   = base_cnt + CNT_BITS'(base_cnt != CntMax);
    period    = (spb_i == '0) ? CNT_BITS'(1) : spb_i;
    bit_end   = new_cnt >= period;
    twice     = {new_tally, 1'b0};
    bit_val   = fsk ? (twice < {1'b0, period}) : (twice > {1'b0, period});

    if (bit_end) begin
      integ_p_d = '0;
      integ_m_d = '0;
      count_d   = '0;
      tally_d   = '0;
    end else begin
      integ_p_d = new_p;
      integ_m_d = new_m;
      count_d   = new_cnt;
      tally_d   = new_tally;
    end

    if (en_i) begin
      out_valid_d = mix_i.valid && bit_end;
    end else begin
      out_valid_d = out_valid_q && !out_ready_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_p_q   <= '0;
      integ_m_q   <= '0;
      count_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (en_i && mix_i.valid) begin
        integ_p_q <= integ_p_d;
        integ_m_q <= integ_m_d;
        count_q   <= count_d;
        tally_q   <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && mix_i.valid && bit_end) begin
      out_bit_q   <= bit_val;
      out_count_q <= new_tally;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_bit_o   = out_bit_q;
  assign out_count_o = out_count_q;

endmodule

`default_nettype wire

// ===== src/coherent_ask_psk_fsk_demodulator_core.sv =====
// Pipeline: the sample that ends a bit passes the input, product and result registers
// before its result word is valid.
// Throughput: one sample per cycle; the pipeline stalls only while a result waits.
// The integrator add, saturation and mode compare are combinational per sample.
// Reset: phases, integrators and counters clear at once; the configuration
// returns to ASK, 2000 samples per bit and the default tones and threshold.
// ----------------------------------------------------------------------------
// coherent_ask_psk_fsk_demodulator_core: ASK/PSK/FSK correlation demodulator
// Configuration registers, stream ports and the three pipeline parts.
// ----------------------------------------------------------------------------
`default_nettype none

module coherent_ask_psk_fsk_demodulator_core
  import capfd_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  wire logic [IN_TDATA_BITS-1:0]  s_axis_tdata_i,  // [15:0] sample
  input  wire logic [0:0]                s_axis_tuser_i,  // [0] frame_start
  output logic                           m_axis_tvalid_o,
  input  wire logic                      m_axis_tready_i,
  output logic [OUT_TDATA_BITS-1:0]      m_axis_tdata_o,  // [0] decided_bit,
                                                          // [16:1] ones_count
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_BITS-1:0]  cfg_data_i
);

  logic [MODE_BITS-1:0]       mode_q;
  logic [CNT_BITS-1:0]        spb_q;
  logic [PHASE_BITS-1:0]      carrier_inc_q, space_inc_q, mark_inc_q;
  logic signed [ACC_BITS-1:0] threshold_q;

  logic                en, accept;
  carrier_t            carrier;
  mix_t                mix;
  logic                out_bit;
  logic [CNT_BITS-1:0] out_count;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_ASK;
      spb_q         <= SPB_RESET;
      carrier_inc_q <= CARRIER_RESET;
      space_inc_q   <= SPACE_RESET;
      mark_inc_q    <= MARK_RESET;
      threshold_q   <= THRESHOLD_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MODE:      mode_q        <= cfg_data_i[MODE_BITS-1:0];
        CFG_SPB:       spb_q         <= cfg_data_i[CNT_BITS-1:0];
        CFG_CARRIER:   carrier_inc_q <= cfg_data_i[PHASE_BITS-1:0];
        CFG_SPACE:     space_inc_q   <= cfg_data_i[PHASE_BITS-1:0];
        CFG_MARK:      mark_inc_q    <= cfg_data_i[PHASE_BITS-1:0];
        CFG_THRESHOLD: threshold_q   <= cfg_data_i[ACC_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // advance the whole pipeline unless a result word is held
  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign accept          = s_axis_tvalid_i && en;

  capfd_nco u_nco (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (accept),
    .frame_start_i (s_axis_tuser_i[0]),
    .fsk_i         (mode_q[MODE_FSK_BIT]),
    .carrier_inc_i (carrier_inc_q),
    .space_inc_i   (space_inc_q),
    .mark_inc_i    (mark_inc_q),
    .carrier_o     (carrier)
  );

  capfd_mixer u_mixer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .accept_i      (accept),
    .sample_i      (s_axis_tdata_i[SAMPLE_BITS-1:0]),
    .frame_start_i (s_axis_tuser_i[0]),
    .carrier_i     (carrier),
    .mix_o         (mix)
  );

  capfd_decider u_decider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .mix_i       (mix),
    .mode_i      (mode_q),
    .spb_i       (spb_q),
    .threshold_i (threshold_q),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_bit_o   (out_bit),
    .out_count_o (out_count)
  );

  assign m_axis_tdata_o = {(OUT_TDATA_BITS-CNT_BITS-1)'(0), out_count, out_bit};

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the coherent ASK/PSK/FSK demodulator
// Streams received samples under random source gaps and sink stalls, keeps a
// bit-exact software demodulator in step with every accepted word, and
// compares each decided bit and its ones count against it.
// ----------------------------------------------------------------------------

module tb_top;
  import capfd_pkg::*;

  localparam int     LIMIT_CYCLES = 400_000;
  localparam int     DRAIN_CYCLES = 12;
  localparam longint ACC_HI       = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO       = -ACC_HI - 1;
  localparam int     SPB_MAX      = (1 << CNT_BITS) - 1;
  localparam int     LONG_RUN     = 40;

  // register indexes that map to nothing
  localparam logic [CFG_INDEX_BITS-1:0] IDX_UNMAPPED_LO = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] IDX_UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic                decided;
    logic [CNT_BITS-1:0] ones;
  } bit_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                      s_tvalid  = 1'b0;
  logic [IN_TDATA_BITS-1:0]  s_tdata   = '0;
  logic [0:0]                s_tuser   = '0;
  logic                      m_tready  = 1'b0;
  logic                      cfg_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

  logic                      s_axis_tready_o;
  logic                      m_axis_tvalid_o;
  logic [OUT_TDATA_BITS-1:0] m_axis_tdata_o;
  logic                      cfg_ready_o;

  coherent_ask_psk_fsk_demodulator_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  // demodulator mirror: registers and running state
  logic [MODE_BITS-1:0]         cur_mode    = MODE_ASK;
  logic [CNT_BITS-1:0]          cur_spb     = SPB_RESET;
  logic [PHASE_BITS-1:0]        cur_carrier = CARRIER_RESET;
  logic [PHASE_BITS-1:0]        cur_space   = SPACE_RESET;
  logic [PHASE_BITS-1:0]        cur_mark    = MARK_RESET;
  logic signed [ACC_BITS-1:0]   cur_thr     = THRESHOLD_RESET;
  logic [PHASE_BITS-1:0]        lo_phase    = '0;
  logic [PHASE_BITS-1:0]        mark_phase  = '0;
  longint                       lo_sum      = 0;
  longint                       mark_sum    = 0;
  int unsigned                  bit_fill    = 0;
  int unsigned                  ones_fill   = 0;

  bit_result_t pending_bits[$];

  bit calm      = 1'b0;
  bit tone_sign = 1'b0;
  int n_errors  = 0;
  int n_samples = 0;
  int n_bits    = 0;
  int n_writes  = 0;
  int cycle_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $error("timeout after %0d cycles, %0d bits still pending", cycle_cnt,
             pending_bits.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Q1.14 sine of the top address bits of a phase, folded into one quadrant
  function automatic longint carrier_sine(logic [PHASE_BITS-1:0] ph);
    longint unsigned           divs [5] = '{110, 72, 42, 20, 6};
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    longint unsigned           fold, x, x2, t, mag;
    idx  = ph[PHASE_BITS-1 -: SINE_ADDR_BITS];
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    fold = idx % QUARTER_LEN;
    if (quad[0]) begin
      fold = QUARTER_LEN - fold;
    end
    x  = (fold * HALF_PI_Q30) >> QUARTER_BITS;
    x2 = (x * x) >> 30;
    t  = ONE_Q30;
    foreach (divs[k]) begin
      t = ONE_Q30 - ((x2 * t) >> 30) / divs[k];
    end
    mag = (x * t) >> 30;
    mag = (mag + (64'd1 << 15)) >> 16;
    return quad[1] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clamp_acc(longint v);
    if (v > ACC_HI) begin
      return ACC_HI;
    end
    if (v < ACC_LO) begin
      return ACC_LO;
    end
    return v;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                    logic [CFG_DATA_BITS-1:0] data);
    case (idx)
      CFG_MODE:      cur_mode    = data[MODE_BITS-1:0];
      CFG_SPB:       cur_spb     = data[CNT_BITS-1:0];
      CFG_CARRIER:   cur_carrier = data[PHASE_BITS-1:0];
      CFG_SPACE:     cur_space   = data[PHASE_BITS-1:0];
      CFG_MARK:      cur_mark    = data[PHASE_BITS-1:0];
      CFG_THRESHOLD: cur_thr     = data[ACC_BITS-1:0];
      default: ;
    endcase
  endfunction

  // mix, integrate, compare and vote for one accepted sample
  function automatic void demod_step(logic [SAMPLE_BITS-1:0] smp_bits, logic fs);
    logic        fsk;
    logic        one;
    longint      smp;
    int unsigned period;
    int unsigned twice;
    bit_result_t res;
    fsk    = cur_mode[MODE_FSK_BIT];
    smp    = longint'($signed(smp_bits));
    period = (cur_spb == '0) ? 1 : cur_spb;
    if (fs) begin
      lo_phase   = '0;
      mark_phase = '0;
      lo_sum     = 0;
      mark_sum   = 0;
      bit_fill   = 0;
      ones_fill  = 0;
    end
    lo_sum     = clamp_acc(lo_sum + smp * carrier_sine(lo_phase));
    mark_sum   = clamp_acc(mark_sum + smp * carrier_sine(mark_phase));
    lo_phase   = lo_phase + (fsk ? cur_space : cur_carrier);
    mark_phase = mark_phase + cur_mark;
    if (fsk) begin
      one = lo_sum > mark_sum;
    end else if (cur_mode == MODE_PSK) begin
      one = lo_sum < 0;
    end else begin
      one = lo_sum > longint'(cur_thr);
    end
    if (one && ones_fill < SPB_MAX) begin
      ones_fill++;
    end
    if (bit_fill < SPB_MAX) begin
      bit_fill++;
    end
    if (bit_fill >= period) begin
      twice        = 2 * ones_fill;
      res.decided  = fsk ? (twice < period) : (twice > period);
      res.ones     = ones_fill[CNT_BITS-1:0];
      pending_bits = {pending_bits, res};
      lo_sum    = 0;
      mark_sum  = 0;
      bit_fill  = 0;
      ones_fill = 0;
    end
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [SAMPLE_BITS-1:0] corner_vals [5] =
      '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
    int amp;
    case ($urandom_range(0, 9))
      0, 1: return corner_vals[$urandom_range(0, 4)];
      2, 3, 4, 5: return SAMPLE_BITS'($urandom);
      default: begin
        // keying-like signal: a signed level that flips now and then
        if ($urandom_range(0, 7) == 0) begin
          tone_sign = ~tone_sign;
        end
        amp = $urandom_range(8192, 32767);
        return tone_sign ? SAMPLE_BITS'(-amp) : SAMPLE_BITS'(amp);
      end
    endcase
  endfunction

  // sink side: random stall bursts unless the run is calm
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    bit_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (pending_bits.size() == 0) begin
        $error("result word with no bit period pending: tdata=%h", m_axis_tdata_o);
        n_errors++;
      end else begin
        want = pending_bits.pop_front();
        n_bits++;
        if (m_axis_tdata_o[0] !== want.decided) begin
          $error("decided_bit: expected %0b, actual %0b", want.decided,
                 m_axis_tdata_o[0]);
          n_errors++;
        end
        if (m_axis_tdata_o[CNT_BITS:1] !== want.ones) begin
          $error("ones_count: expected %0d, actual %0d", want.ones,
                 m_axis_tdata_o[CNT_BITS:1]);
          n_errors++;
        end
        if (m_axis_tdata_o[OUT_TDATA_BITS-1:CNT_BITS+1] !== '0) begin
          $error("tdata pad: expected 0, actual %h",
                 m_axis_tdata_o[OUT_TDATA_BITS-1:CNT_BITS+1]);
          n_errors++;
        end
      end
    end
  end

  // present one sample word and hold it until accepted
  task automatic push_sample(logic [SAMPLE_BITS-1:0] smp, logic fs);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
    s_tvalid   <= 1'b1;
    s_tdata    <= smp;
    s_tuser[0] <= fs;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    demod_step(smp, fs);
    n_samples++;
  endtask

  // stop the source and let the pipeline empty
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_bits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // valid stays high so back-to-back writes follow without a gap
  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                           logic [CFG_DATA_BITS-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg(idx, data);
    n_writes++;
  endtask

  task automatic cfg_release();
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CFG_DATA_BITS-1:0] pick_increment();
    logic [CFG_DATA_BITS-1:0] data;
    data = CFG_DATA_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 7))
      0: data[PHASE_BITS-1:0] = '0;
      1: data[PHASE_BITS-1:0] = '1;
      default: ;
    endcase
    return data;
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_BITS-1:0] data;
    longint                   thr;
    drain();
    data = CFG_DATA_BITS'({$urandom, $urandom});
    write_reg(CFG_MODE, data);
    data = CFG_DATA_BITS'({$urandom, $urandom});
    case ($urandom_range(0, 9))
      0: data[CNT_BITS-1:0] = '0;
      1: data[CNT_BITS-1:0] = 16'd1;
      default: data[CNT_BITS-1:0] = CNT_BITS'($urandom_range(2, 24));
    endcase
    write_reg(CFG_SPB, data);
    write_reg(CFG_CARRIER, pick_increment());
    write_reg(CFG_SPACE, pick_increment());
    write_reg(CFG_MARK, pick_increment());
    thr = longint'(int'($urandom)) <<< $urandom_range(0, 3);
    case ($urandom_range(0, 9))
      0: data = {1'b1, {(ACC_BITS-1){1'b0}}};
      1: data = {1'b0, {(ACC_BITS-1){1'b1}}};
      2: data = CFG_DATA_BITS'({$urandom, $urandom});
      default: data = CFG_DATA_BITS'(thr);
    endcase
    write_reg(CFG_THRESHOLD, data);
    if ($urandom_range(0, 3) == 0) begin
      write_reg($urandom_range(0, 1) ? IDX_UNMAPPED_LO : IDX_UNMAPPED_HI,
                CFG_DATA_BITS'({$urandom, $urandom}));
    end
    cfg_release();
  endtask

  // reset values: a few samples at the default period, then shorten it
  task automatic test_reset_defaults();
    for (int i = 0; i < 8; i++) begin
      push_sample(i < 4 ? 16'h7FFF : SAMPLE_BITS'($urandom), 1'b0);
    end
    drain();
    write_reg(CFG_SPB, 48'd5);
    cfg_release();
    push_sample(16'h8000, 1'b0);
  endtask

  // each demodulation rule, mode three included, with full-scale, zero and random samples
  task automatic test_each_mode();
    drain();
    write_reg(CFG_SPB, 48'd3);
    write_reg(CFG_CARRIER, 48'h0000_4000_0000);
    write_reg(CFG_SPACE, 48'hFFFF_8000_0000);
    write_reg(CFG_MARK, 48'h0000_2000_0000);
    write_reg(CFG_THRESHOLD, 48'h0);
    cfg_release();
    for (int m = 0; m < 4; m++) begin
      drain();
      write_reg(CFG_MODE, CFG_DATA_BITS'(m));
      cfg_release();
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h0000, 1'b0);
      push_sample(SAMPLE_BITS'($urandom), 1'b0);
    end
  endtask

  // a zero period behaves as one; unmapped indexes change nothing
  task automatic test_zero_period();
    drain();
    write_reg(CFG_SPB, 48'hFFFF_FFFF_0000);
    write_reg(IDX_UNMAPPED_LO, '1);
    write_reg(IDX_UNMAPPED_HI, '1);
    cfg_release();
    push_sample(16'h7FFF, 1'b0);
    push_sample(16'h8000, 1'b0);
  endtask

  // a run at the longest period fed back to back, then cut short mid-bit
  task automatic test_longest_period();
    drain();
    calm = 1'b1;
    write_reg(CFG_MODE, CFG_DATA_BITS'(MODE_PSK));
    write_reg(CFG_CARRIER, CFG_DATA_BITS'($urandom));
    write_reg(CFG_SPB, CFG_DATA_BITS'(SPB_MAX));
    cfg_release();
    push_sample(pick_sample(), 1'b1);
    for (int i = 1; i < LONG_RUN; i++) begin
      push_sample(pick_sample(), 1'b0);
    end
    drain();
    write_reg(CFG_SPB, 48'd24);
    cfg_release();
    push_sample(pick_sample(), 1'b0);
    drain();
    calm = 1'b0;
  endtask

  task automatic test_random_phases();
    int n;
    for (int p = 0; p < 8; p++) begin
      random_settings();
      n = $urandom_range(90, 115);
      for (int i = 0; i < n; i++) begin
        push_sample(pick_sample(), $urandom_range(0, 24) == 0);
      end
    end
  endtask

  // closing stretch with neither side idling
  task automatic test_calm_tail();
    calm = 1'b1;
    random_settings();
    for (int i = 0; i < 70; i++) begin
      push_sample(pick_sample(), $urandom_range(0, 24) == 0);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_each_mode();
    test_zero_period();
    test_longest_period();
    test_random_phases();
    test_calm_tail();
    drain();
    $display("Fed %0d samples through %0d register writes; %0d decided bits checked.",
             n_samples, n_writes, n_bits);
    $display("Modes ASK, PSK, FSK and mode three; periods 0 to 65535; %0d mismatches.",
             n_errors);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/capfd_pkg.sv
src/capfd_nco.sv
src/capfd_mixer.sv
src/capfd_decider.sv
src/coherent_ask_psk_fsk_demodulator_core.sv
test/tb_top.sv
